/* rtl/nnsa_pkg.sv */
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared types and constants for the nearest-neighbor scale address unit.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int COORD_W  = 12;  // pixel coordinate
  localparam int OFFS_W   = 26;  // byte offset
  localparam int DIM_W    = 13;  // width/height register
  localparam int LINE_W   = 15;  // line bytes register
  localparam int BPP_W    = 6;   // bits per pixel register
  localparam int CFG_W    = 15;  // widest register
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEPTH = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SRC_LINE   = 3'd4,
    REG_DST_LINE   = 3'd5,
    REG_SRC_BPP    = 3'd6,
    REG_DST_BPP    = 3'd7
  } cfg_idx_t;

  // Side data that rides along the divider chain
  typedef struct packed {
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
    status_t            status;
  } tag_t;

endpackage

/* rtl/nnsa_if.sv */
// ----------------------------------------------------------------------------
// nnsa_in_if / nnsa_out_if
// Valid/ready channels for destination coordinates and address results.
// ----------------------------------------------------------------------------
interface nnsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [nnsa_pkg::COORD_W-1:0] dst_col;
  logic [nnsa_pkg::COORD_W-1:0] dst_row;

  modport source (output valid, output dst_col, output dst_row, input ready);
  modport sink   (input valid, input dst_col, input dst_row, output ready);
endinterface

interface nnsa_out_if;
  logic                         valid;
  logic                         ready;
  logic [nnsa_pkg::COORD_W-1:0] src_col;
  logic [nnsa_pkg::COORD_W-1:0] src_row;
  logic [nnsa_pkg::OFFS_W-1:0]  src_offset;
  logic [nnsa_pkg::OFFS_W-1:0]  dst_offset;
  logic [1:0]                   status;

  modport source (output valid, output src_col, output src_row, output src_offset,
                  output dst_offset, output status, input ready);
  modport sink   (input valid, input src_col, input src_row, input src_offset,
                  input dst_offset, input status, output ready);
endinterface

/* rtl/nnsa_div_cell.sv */
// ----------------------------------------------------------------------------
// nnsa_div_cell
// One restoring-division cell: resolves quotient bit BIT for the column and
// the row divide, then hands the partial remainders to the next cell.
// ----------------------------------------------------------------------------
module nnsa_div_cell #(
  parameter int CW  = 13,
  parameter int RW  = 38,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  output logic                dn_valid,
  input  logic                dn_ready,
  input  logic [CW-1:0]       div_col,
  input  logic [CW-1:0]       div_row,
  input  logic [RW-1:0]       rem_col_i,
  input  logic [RW-1:0]       rem_row_i,
  input  logic [CW-1:0]       q_col_i,
  input  logic [CW-1:0]       q_row_i,
  input  nnsa_pkg::tag_t      tag_i,
  output logic [RW-1:0]       rem_col_o,
  output logic [RW-1:0]       rem_row_o,
  output logic [CW-1:0]       q_col_o,
  output logic [CW-1:0]       q_row_o,
  output nnsa_pkg::tag_t      tag_o
);

  logic               v_r, v_nxt;
  logic [RW-1:0]      rem_col_r, rem_col_nxt;
  logic [RW-1:0]      rem_row_r, rem_row_nxt;
  logic [CW-1:0]      q_col_r, q_col_nxt;
  logic [CW-1:0]      q_row_r, q_row_nxt;
  nnsa_pkg::tag_t     tag_r;
  logic [RW-1:0]      sd_col, sd_row;
  logic               ge_col, ge_row;
  logic [CW-1:0]      qbit;

  assign up_ready = !v_r || dn_ready;
  assign sd_col   = RW'(div_col) << BIT;
  assign sd_row   = RW'(div_row) << BIT;
  assign ge_col   = rem_col_i >= sd_col;
  assign ge_row   = rem_row_i >= sd_row;
  assign qbit     = CW'(1) << BIT;

  always_comb begin
    v_nxt       = up_ready ? up_valid : v_r;
    rem_col_nxt = ge_col ? rem_col_i - sd_col : rem_col_i;
    rem_row_nxt = ge_row ? rem_row_i - sd_row : rem_row_i;
    q_col_nxt   = ge_col ? (q_col_i | qbit) : q_col_i;
    q_row_nxt   = ge_row ? (q_row_i | qbit) : q_row_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_col_r <= rem_col_nxt;
      rem_row_r <= rem_row_nxt;
      q_col_r   <= q_col_nxt;
      q_row_r   <= q_row_nxt;
      tag_r     <= tag_i;
    end
  end

  assign dn_valid  = v_r;
  assign rem_col_o = rem_col_r;
  assign rem_row_o = rem_row_r;
  assign q_col_o   = q_col_r;
  assign q_row_o   = q_row_r;
  assign tag_o     = tag_r;

`ifndef SYNTHESIS
  // Bits below this cell are still unresolved and must be clear
  a_low_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> ((q_col_r & (qbit - CW'(1))) == '0) && ((q_row_r & (qbit - CW'(1))) == '0))
    else $error("quotient bits below the cell position are set");
`endif

endmodule

/* rtl/nearest_neighbor_scale_address_unit.sv */
// Pipeline from input beat to result beat: one entry stage with the scale multiplies,
//   one divider cell per quotient bit, one offset multiply stage, the output register.
// Throughput: one beat per cycle unless the result channel stalls;
//   the divider chain resolves one quotient bit per cell.
// Reset: synchronous, active low; clears all stage valids and loads register defaults.
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address_unit
// Maps a destination pixel to its nearest source pixel and returns source and
// destination byte offsets, through a chain of division cells.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  nnsa_in_if.sink                        in_bus,
  nnsa_out_if.source                     out_bus,
  input  logic                           cfg_we,
  input  logic [nnsa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [nnsa_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CLOG = $clog2(MAX_DIM + 1);
  localparam int CW   = (CLOG < nnsa_pkg::DIM_W) ? CLOG : nnsa_pkg::DIM_W;
  localparam int XW   = nnsa_pkg::COORD_W;
  localparam int QW   = (CW > XW) ? CW : XW;
  localparam int PW   = XW + CW;
  localparam int RW   = XW + 2 * CW;
  localparam int MW   = QW + nnsa_pkg::LINE_W;
  localparam int BW   = QW + 3;

  // Configuration registers
  logic [nnsa_pkg::DIM_W-1:0]  src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [nnsa_pkg::LINE_W-1:0] src_line_r, dst_line_r;
  logic [nnsa_pkg::BPP_W-1:0]  src_bpp_r, dst_bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= nnsa_pkg::DIM_W'(1);
      src_height_r <= nnsa_pkg::DIM_W'(1);
      dst_width_r  <= nnsa_pkg::DIM_W'(1);
      dst_height_r <= nnsa_pkg::DIM_W'(1);
      src_line_r   <= nnsa_pkg::LINE_W'(1);
      dst_line_r   <= nnsa_pkg::LINE_W'(1);
      src_bpp_r    <= nnsa_pkg::BPP_W'(8);
      dst_bpp_r    <= nnsa_pkg::BPP_W'(8);
    end else if (cfg_we) begin
      unique case (nnsa_pkg::cfg_idx_t'(cfg_idx))
        nnsa_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_wdata[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_wdata[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::REG_DST_WIDTH:  dst_width_r  <= cfg_wdata[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::REG_DST_HEIGHT: dst_height_r <= cfg_wdata[nnsa_pkg::DIM_W-1:0];
        nnsa_pkg::REG_SRC_LINE:   src_line_r   <= cfg_wdata;
        nnsa_pkg::REG_DST_LINE:   dst_line_r   <= cfg_wdata;
        nnsa_pkg::REG_SRC_BPP:    src_bpp_r    <= cfg_wdata[nnsa_pkg::BPP_W-1:0];
        nnsa_pkg::REG_DST_BPP:    dst_bpp_r    <= cfg_wdata[nnsa_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions to MAX_DIM
  logic [CW-1:0] sw_c, sh_c, dw_c, dh_c;
  assign sw_c = (32'(src_width_r)  > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(src_width_r);
  assign sh_c = (32'(src_height_r) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(src_height_r);
  assign dw_c = (32'(dst_width_r)  > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dst_width_r);
  assign dh_c = (32'(dst_height_r) > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dst_height_r);

  // Chain links: index 0 is the entry stage, index CW the last cell
  logic          cv     [CW+1];
  logic          cready [CW+1];
  logic [RW-1:0] crc    [CW+1];
  logic [RW-1:0] crr    [CW+1];
  logic [CW-1:0] cqc    [CW+1];
  logic [CW-1:0] cqr    [CW+1];
  nnsa_pkg::tag_t ctag  [CW+1];

  logic ready_m, ready_o;

  // Entry stage: scale multiplies and status
  logic           v0_r, v0_nxt, ready_0;
  logic [RW-1:0]  rc0_r, rr0_r;
  nnsa_pkg::tag_t tag0_r, tag0_nxt;
  logic [PW-1:0]  pc, pr;

  assign ready_0      = !v0_r || cready[0];
  assign in_bus.ready = ready_0;
  assign pc = PW'(in_bus.dst_col) * PW'(sw_c);
  assign pr = PW'(in_bus.dst_row) * PW'(sh_c);

  always_comb begin
    v0_nxt           = ready_0 ? in_bus.valid : v0_r;
    tag0_nxt.dst_col = in_bus.dst_col;
    tag0_nxt.dst_row = in_bus.dst_row;
    priority if (src_bpp_r != dst_bpp_r) begin
      tag0_nxt.status = nnsa_pkg::ST_DEPTH;
    end else if ((32'(in_bus.dst_col) >= 32'(dw_c)) || (32'(in_bus.dst_row) >= 32'(dh_c))) begin
      tag0_nxt.status = nnsa_pkg::ST_RANGE;
    end else begin
      tag0_nxt.status = nnsa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_0 && in_bus.valid) begin
      rc0_r  <= RW'(pc);
      rr0_r  <= RW'(pr);
      tag0_r <= tag0_nxt;
    end
  end

  assign cv[0]   = v0_r;
  assign crc[0]  = rc0_r;
  assign crr[0]  = rr0_r;
  assign cqc[0]  = '0;
  assign cqr[0]  = '0;
  assign ctag[0] = tag0_r;

  // Division chain, most significant quotient bit first
  for (genvar i = 0; i < CW; i++) begin : g_cell
    nnsa_div_cell #(.CW(CW), .RW(RW), .BIT(CW - 1 - i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (cv[i]),
      .up_ready  (cready[i]),
      .dn_valid  (cv[i+1]),
      .dn_ready  (cready[i+1]),
      .div_col   (dw_c),
      .div_row   (dh_c),
      .rem_col_i (crc[i]),
      .rem_row_i (crr[i]),
      .q_col_i   (cqc[i]),
      .q_row_i   (cqr[i]),
      .tag_i     (ctag[i]),
      .rem_col_o (crc[i+1]),
      .rem_row_o (crr[i+1]),
      .q_col_o   (cqc[i+1]),
      .q_row_o   (cqr[i+1]),
      .tag_o     (ctag[i+1])
    );
  end

  assign cready[CW] = ready_m;

  // Offset multiply stage: the full quotient feeds the source offset
  logic           vm_r, vm_nxt;
  logic [QW-1:0]  scol, srow;
  logic [XW-1:0]  scol_m_r, srow_m_r;
  logic [MW-1:0]  p_srow_r, p_row_r;
  logic [BW-1:0]  p_scol_r, p_col_r;
  nnsa_pkg::status_t st_m_r;

  assign ready_m = !vm_r || ready_o;
  assign scol    = QW'(cqc[CW]);
  assign srow    = QW'(cqr[CW]);
  assign vm_nxt  = ready_m ? cv[CW] : vm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else begin
      vm_r <= vm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_m && cv[CW]) begin
      scol_m_r <= XW'(scol);
      srow_m_r <= XW'(srow);
      p_srow_r <= MW'(srow) * MW'(src_line_r);
      p_scol_r <= BW'(scol) * BW'(src_bpp_r[nnsa_pkg::BPP_W-1:3]);
      p_row_r  <= MW'(ctag[CW].dst_row) * MW'(dst_line_r);
      p_col_r  <= BW'(ctag[CW].dst_col) * BW'(dst_bpp_r[nnsa_pkg::BPP_W-1:3]);
      st_m_r   <= ctag[CW].status;
    end
  end

  // Output register: sums, and zero fields on error beats
  logic                        vo_r, vo_nxt, ok_m;
  logic [XW-1:0]               src_col_r, src_row_r;
  logic [nnsa_pkg::OFFS_W-1:0] src_off_r, dst_off_r;
  nnsa_pkg::status_t           st_o_r;

  assign ready_o = !vo_r || out_bus.ready;
  assign vo_nxt  = ready_o ? vm_r : vo_r;
  assign ok_m    = (st_m_r == nnsa_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vm_r) begin
      st_o_r <= st_m_r;
      if (ok_m) begin
        src_col_r <= scol_m_r;
        src_row_r <= srow_m_r;
        src_off_r <= nnsa_pkg::OFFS_W'(p_srow_r + MW'(p_scol_r));
        dst_off_r <= nnsa_pkg::OFFS_W'(p_row_r + MW'(p_col_r));
      end else begin
        src_col_r <= '0;
        src_row_r <= '0;
        src_off_r <= '0;
        dst_off_r <= '0;
      end
    end
  end

  assign out_bus.valid      = vo_r;
  assign out_bus.src_col    = src_col_r;
  assign out_bus.src_row    = src_row_r;
  assign out_bus.src_offset = src_off_r;
  assign out_bus.dst_offset = dst_off_r;
  assign out_bus.status     = st_o_r;

`ifndef SYNTHESIS
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r && (st_o_r != nnsa_pkg::ST_OK) |->
      (src_col_r == '0) && (src_row_r == '0) && (src_off_r == '0) && (dst_off_r == '0))
    else $error("error beat carries nonzero address fields");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !vo_r |-> in_bus.ready)
    else $error("input stalled while output register is empty");

  a_out_from_mult: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vo_r) |-> $past(vm_r))
    else $error("result appeared without a beat in the multiply stage");
`endif

endmodule

/* dv/tb_nearest_neighbor_scale_address_unit.sv */
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_scale_address_unit
// Self-checking bench for the scale address unit. A short table of directed
// coordinates and register writes comes first: reset values, extreme sizes,
// depth mismatch, coordinates outside the destination, clamped and zero
// dimensions, odd pixel depths and wrapping offsets. Random register settings
// and coordinate streams follow. Every result beat is compared field by field
// against an in-bench address predictor, with random idling on both channels
// and one long result stall.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_scale_address_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = nnsa_pkg::COORD_W;
  localparam int OFFS_W  = nnsa_pkg::OFFS_W;
  localparam int DIM_W   = nnsa_pkg::DIM_W;
  localparam int LINE_W  = nnsa_pkg::LINE_W;
  localparam int BPP_W   = nnsa_pkg::BPP_W;
  localparam int CFG_W   = nnsa_pkg::CFG_W;

  localparam int unsigned DIM_LIMIT       = 4096;
  localparam int unsigned BITS_PER_BYTE   = 8;
  localparam int unsigned PHASES          = 13;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  localparam int unsigned HOLD_PHASE      = 2;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_LIMIT     = 20000;
  localparam int unsigned TAIL_CYCLES     = 40;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned WATCHDOG_NS     = 2_000_000;
  localparam int unsigned COORD_MAX       = (1 << COORD_W) - 1;
  localparam int unsigned CFG_MAX         = (1 << CFG_W) - 1;
  localparam logic [CFG_W-1:0] BPP_MASK   = CFG_W'((1 << BPP_W) - 1);

  typedef struct packed {
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [OFFS_W-1:0]  src_offset;
    logic [OFFS_W-1:0]  dst_offset;
    nnsa_pkg::status_t  status;
  } addr_result_t;

  typedef struct packed {
    logic         known;
    addr_result_t want;
  } table_note_t;

  typedef struct {
    logic               is_write;
    nnsa_pkg::cfg_idx_t idx;
    logic [CFG_W-1:0]   wdata;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               known;
    addr_result_t       want;
  } addr_vector_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  nnsa_pkg::cfg_idx_t   cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  nnsa_in_if  in_bus ();
  nnsa_out_if out_bus ();

  logic [CFG_W-1:0]     reg_shadow [8];
  addr_result_t         pending_addr_q [$];
  table_note_t          typed_addr_q [$];
  int unsigned          fault_count = 0;
  int unsigned          results_seen = 0;
  bit                   src_idle_en;
  bit                   sink_idle_en;
  bit                   hold_sink;

  nearest_neighbor_scale_address_unit #(
    .MAX_DIM (DIM_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Address predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned dim_of(nnsa_pkg::cfg_idx_t idx);
    return (reg_shadow[idx] > DIM_LIMIT) ? DIM_LIMIT : reg_shadow[idx];
  endfunction

  function automatic addr_result_t scale_address(logic [COORD_W-1:0] col,
                                                 logic [COORD_W-1:0] row);
    longint unsigned sw, sh, dw, dh, scol, srow, sbytes, dbytes;
    addr_result_t    res;
    sw  = dim_of(nnsa_pkg::REG_SRC_WIDTH);
    sh  = dim_of(nnsa_pkg::REG_SRC_HEIGHT);
    dw  = dim_of(nnsa_pkg::REG_DST_WIDTH);
    dh  = dim_of(nnsa_pkg::REG_DST_HEIGHT);
    res = '0;
    if (reg_shadow[nnsa_pkg::REG_SRC_BPP] != reg_shadow[nnsa_pkg::REG_DST_BPP]) begin
      res.status = nnsa_pkg::ST_DEPTH;
    end else if (col >= dw || row >= dh) begin
      res.status = nnsa_pkg::ST_RANGE;
    end else begin
      scol   = col * sw / dw;
      srow   = row * sh / dh;
      sbytes = reg_shadow[nnsa_pkg::REG_SRC_BPP] / BITS_PER_BYTE;
      dbytes = reg_shadow[nnsa_pkg::REG_DST_BPP] / BITS_PER_BYTE;
      res.src_col    = COORD_W'(scol);
      res.src_row    = COORD_W'(srow);
      res.src_offset = OFFS_W'(srow * reg_shadow[nnsa_pkg::REG_SRC_LINE] + scol * sbytes);
      res.dst_offset = OFFS_W'(row * reg_shadow[nnsa_pkg::REG_DST_LINE] + col * dbytes);
      res.status     = nnsa_pkg::ST_OK;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: check result beats, track register writes, predict on accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    addr_result_t got;
    addr_result_t want;
    table_note_t  note;
    if (!rst_n) begin
      reg_shadow[nnsa_pkg::REG_SRC_WIDTH]  = CFG_W'(1);
      reg_shadow[nnsa_pkg::REG_SRC_HEIGHT] = CFG_W'(1);
      reg_shadow[nnsa_pkg::REG_DST_WIDTH]  = CFG_W'(1);
      reg_shadow[nnsa_pkg::REG_DST_HEIGHT] = CFG_W'(1);
      reg_shadow[nnsa_pkg::REG_SRC_LINE]   = CFG_W'(1);
      reg_shadow[nnsa_pkg::REG_DST_LINE]   = CFG_W'(1);
      reg_shadow[nnsa_pkg::REG_SRC_BPP]    = CFG_W'(BITS_PER_BYTE);
      reg_shadow[nnsa_pkg::REG_DST_BPP]    = CFG_W'(BITS_PER_BYTE);
      pending_addr_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.src_col    = out_bus.src_col;
        got.src_row    = out_bus.src_row;
        got.src_offset = out_bus.src_offset;
        got.dst_offset = out_bus.dst_offset;
        got.status     = nnsa_pkg::status_t'(out_bus.status);
        if (pending_addr_q.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = pending_addr_q.pop_front();
          if (got.src_col !== want.src_col || got.src_row !== want.src_row ||
              got.src_offset !== want.src_offset ||
              got.dst_offset !== want.dst_offset || got.status !== want.status) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
              $display("result %0d mismatch: expected col %0d row %0d src_off %0d dst_off %0d status %0d",
                       results_seen, want.src_col, want.src_row, want.src_offset,
                       want.dst_offset, want.status);
              $display("result %0d mismatch: got      col %0d row %0d src_off %0d dst_off %0d status %0d",
                       results_seen, got.src_col, got.src_row, got.src_offset,
                       got.dst_offset, got.status);
            end
          end
        end
        results_seen++;
      end
      if (cfg_we) begin
        case (cfg_idx)
          nnsa_pkg::REG_SRC_BPP, nnsa_pkg::REG_DST_BPP: begin
            reg_shadow[cfg_idx] = cfg_wdata & BPP_MASK;
          end
          nnsa_pkg::REG_SRC_LINE, nnsa_pkg::REG_DST_LINE: begin
            reg_shadow[cfg_idx] = cfg_wdata & CFG_W'((1 << LINE_W) - 1);
          end
          default: begin
            reg_shadow[cfg_idx] = cfg_wdata & CFG_W'((1 << DIM_W) - 1);
          end
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        if (typed_addr_q.size() != 0) begin
          note = typed_addr_q.pop_front();
          pending_addr_q.push_back(note.known ? note.want
                                              : scale_address(in_bus.dst_col, in_bus.dst_row));
        end else begin
          pending_addr_q.push_back(scale_address(in_bus.dst_col, in_bus.dst_row));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 48);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 8) return COORD_W'($urandom_range(0, COORD_MAX));
    if (r < 14) return COORD_W'(lim - 1);
    if (r < 18) return '0;
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return CFG_W'($urandom_range(0, CFG_MAX));
    if (r < 18) return CFG_W'(DIM_LIMIT);
    if (r < 55) return CFG_W'($urandom_range(1, 64));
    return CFG_W'($urandom_range(1, DIM_LIMIT));
  endfunction

  function automatic logic [CFG_W-1:0] pick_line();
    if ($urandom_range(0, 99) < 8) return CFG_W'($urandom_range(0, CFG_MAX));
    return CFG_W'($urandom_range(1, 16384));
  endfunction

  function automatic addr_vector_t reg_row(nnsa_pkg::cfg_idx_t idx, int unsigned value);
    addr_vector_t v;
    v.is_write = 1'b1;
    v.idx      = idx;
    v.wdata    = CFG_W'(value);
    v.col      = '0;
    v.row      = '0;
    v.known    = 1'b0;
    v.want     = '0;
    return v;
  endfunction

  function automatic addr_vector_t pix_row(int unsigned col, int unsigned row);
    addr_vector_t v;
    v.is_write = 1'b0;
    v.idx      = nnsa_pkg::REG_SRC_WIDTH;
    v.wdata    = '0;
    v.col      = COORD_W'(col);
    v.row      = COORD_W'(row);
    v.known    = 1'b0;
    v.want     = '0;
    return v;
  endfunction

  function automatic addr_vector_t known_row(int unsigned col, int unsigned row,
                                             int unsigned scol, int unsigned srow,
                                             int unsigned soff, int unsigned doff,
                                             nnsa_pkg::status_t st);
    addr_vector_t v;
    v                 = pix_row(col, row);
    v.known           = 1'b1;
    v.want.src_col    = COORD_W'(scol);
    v.want.src_row    = COORD_W'(srow);
    v.want.src_offset = OFFS_W'(soff);
    v.want.dst_offset = OFFS_W'(doff);
    v.want.status     = st;
    return v;
  endfunction

  task automatic offer_coord(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             int unsigned gap);
    in_bus.valid   <= 1'b1;
    in_bus.dst_col <= col;
    in_bus.dst_row <= row;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected beat is back
  task automatic await_results();
    int unsigned waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_addr_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_reg(nnsa_pkg::cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result channel ready: random runs and gaps, one long hold on request
  // --------------------------------------------------------------------------
  initial begin : sink_ready
    int unsigned run_len;
    int unsigned gap_len;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        run_len = $urandom_range(1, 24);
        out_bus.ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        gap_len = sink_idle_en ? pick_gap() : 0;
        if (gap_len > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap_len) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    addr_vector_t     plan [$];
    table_note_t      note;
    logic [CFG_W-1:0] bpp_a;
    logic [CFG_W-1:0] bpp_b;
    int unsigned      lim_w;
    int unsigned      lim_h;
    int unsigned      r;
    bit               stream_hold;

    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.dst_col = '0;
    in_bus.dst_row = '0;
    cfg_we         = 1'b0;
    cfg_idx        = nnsa_pkg::REG_SRC_WIDTH;
    cfg_wdata      = '0;
    src_idle_en    = 1'b1;
    sink_idle_en   = 1'b1;
    hold_sink      = 1'b0;

    // Reset values: 1x1 image, 8-bit pixels
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, nnsa_pkg::ST_OK));
    plan.push_back(known_row(1, 0, 0, 0, 0, 0, nnsa_pkg::ST_RANGE));
    plan.push_back(known_row(0, 4095, 0, 0, 0, 0, nnsa_pkg::ST_RANGE));
    // Depth mismatch wins over an outside coordinate
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_BPP, 32));
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, nnsa_pkg::ST_DEPTH));
    plan.push_back(known_row(4095, 4095, 0, 0, 0, 0, nnsa_pkg::ST_DEPTH));
    // Full size, source width above the clamp
    plan.push_back(reg_row(nnsa_pkg::REG_DST_BPP, 32));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_WIDTH, 8191));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_HEIGHT, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_WIDTH, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_HEIGHT, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_LINE, 16384));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_LINE, 16384));
    plan.push_back(known_row(4095, 4095, 4095, 4095, 67108860, 67108860, nnsa_pkg::ST_OK));
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, nnsa_pkg::ST_OK));
    plan.push_back(pix_row(4095, 0));
    plan.push_back(pix_row(0, 4095));
    plan.push_back(pix_row(2730, 1365));
    // Zero destination width puts everything outside
    plan.push_back(reg_row(nnsa_pkg::REG_DST_WIDTH, 0));
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, nnsa_pkg::ST_RANGE));
    // All-ones write data, masked and clamped
    plan.push_back(reg_row(nnsa_pkg::REG_DST_WIDTH, CFG_MAX));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_HEIGHT, 1));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_HEIGHT, 1));
    plan.push_back(pix_row(4095, 0));
    plan.push_back(known_row(0, 1, 0, 0, 0, 0, nnsa_pkg::ST_RANGE));
    // Upscale, 24-bit pixels
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_WIDTH, 640));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_HEIGHT, 480));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_WIDTH, 1920));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_HEIGHT, 1080));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_LINE, 1920));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_LINE, 5760));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_BPP, 24));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_BPP, 24));
    plan.push_back(pix_row(1919, 1079));
    plan.push_back(known_row(1920, 0, 0, 0, 0, 0, nnsa_pkg::ST_RANGE));
    plan.push_back(pix_row(959, 539));
    // Depths that are not a multiple of eight, and zero
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_BPP, 63));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_BPP, 63));
    plan.push_back(pix_row(1919, 1079));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_BPP, 0));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_BPP, 0));
    plan.push_back(pix_row(1000, 1000));
    // Widest line registers: offsets wrap
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_BPP, 24));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_BPP, 24));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_WIDTH, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_HEIGHT, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_WIDTH, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_HEIGHT, 4096));
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_LINE, CFG_MAX));
    plan.push_back(reg_row(nnsa_pkg::REG_DST_LINE, CFG_MAX));
    plan.push_back(pix_row(4095, 4095));
    plan.push_back(pix_row(3000, 2047));
    // Strong upscale
    plan.push_back(reg_row(nnsa_pkg::REG_SRC_WIDTH, 3));
    plan.push_back(pix_row(4095, 100));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        await_results();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        note.known = plan[i].known;
        note.want  = plan[i].want;
        typed_addr_q.push_back(note);
        offer_coord(plan[i].col, plan[i].row, pick_gap());
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      await_results();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        bpp_a = CFG_W'(BITS_PER_BYTE * $urandom_range(1, 4));
        bpp_b = bpp_a;
      end else if (r < 80) begin
        bpp_a = CFG_W'($urandom_range(0, (1 << BPP_W) - 1));
        bpp_b = bpp_a;
      end else if (r < 90) begin
        bpp_a = CFG_W'(BITS_PER_BYTE * $urandom_range(1, 4));
        bpp_b = bpp_a ^ CFG_W'($urandom_range(1, (1 << BPP_W) - 1));
      end else begin
        // Upper write bits are dropped by the register
        bpp_a = CFG_W'($urandom_range(0, CFG_MAX));
        bpp_b = (CFG_W'($urandom_range(0, CFG_MAX)) & ~BPP_MASK) | (bpp_a & BPP_MASK);
      end
      write_reg(nnsa_pkg::REG_SRC_WIDTH, pick_dim());
      write_reg(nnsa_pkg::REG_SRC_HEIGHT, pick_dim());
      write_reg(nnsa_pkg::REG_DST_WIDTH, pick_dim());
      write_reg(nnsa_pkg::REG_DST_HEIGHT, pick_dim());
      write_reg(nnsa_pkg::REG_SRC_LINE, pick_line());
      write_reg(nnsa_pkg::REG_DST_LINE, pick_line());
      write_reg(nnsa_pkg::REG_SRC_BPP, bpp_a);
      write_reg(nnsa_pkg::REG_DST_BPP, bpp_b);

      stream_hold  = (phase == HOLD_PHASE);
      src_idle_en  = (phase != 0) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
      hold_sink    = stream_hold;
      lim_w        = 32'(dim_of(nnsa_pkg::REG_DST_WIDTH));
      lim_h        = 32'(dim_of(nnsa_pkg::REG_DST_HEIGHT));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_coord(pick_coord(lim_w), pick_coord(lim_h),
                    (src_idle_en && !stream_hold) ? pick_gap() : 0);
      end
    end

    await_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    fault_count += pending_addr_q.size();
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/nnsa_pkg.sv
rtl/nnsa_if.sv
rtl/nnsa_div_cell.sv
rtl/nearest_neighbor_scale_address_unit.sv
dv/tb_nearest_neighbor_scale_address_unit.sv
